// File: sv/plden_pkg.sv
`default_nettype none
package plden_pkg;

   localparam int RES_WIDTH = 23;
   localparam int KIND_WIDTH = 2;

   localparam logic [KIND_WIDTH-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_POINT  = 2'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_FLUSH  = 2'd2;

   localparam logic OP_POINT  = 1'b0;
   localparam logic OP_PEN_UP = 1'b1;

   localparam logic [RES_WIDTH-1:0] RES_RESET = 23'd256;

   typedef enum logic [1:0] {
      CMD_FLUSH,
      CMD_START,
      CMD_SEGMENT
   } cmd_type;

endpackage
`default_nettype wire

// File: sv/polyline_densifier.sv
// Polyline densifier. Takes a stream of signed fixed-point 2-D points and
// pen-up beats. Every point leaves as an original point (kind 1); a pen-up
// leaves as a flush marker (kind 2, zero coordinates) and restarts the line.
// Before a point that follows another on the same line, the block emits
// ceil(length/resolution)-1 evenly spaced points (kind 0) along the segment
// from the previous point, at most MAX_INSERTS of them, and marks every beat
// of that input with clipped when more than that were needed; last marks the
// final beat of each input. The front end classifies beats and tracks the
// anchor, a two-entry queue decouples it from the back end that does the
// arithmetic, and an output register holds each result beat. In the back
// end a start point or pen-up goes straight to its final beat. A segment is
// squared and summed, its length is found by a square root (one digit a
// cycle), the inserts are counted up to MAX_INSERTS+1, the two parallel
// dividers find the step (COORD_WIDTH+24 quotient bits), and the inserted
// beats go out one per cycle unless the output stalls, before the original
// point. The resolution register (reset 256) must be written only while the
// block is idle; the block itself does not enforce this.
`default_nettype none
module polyline_densifier
   import plden_pkg::*;
#(
   parameter int MAX_INSERTS = 63,
   parameter int COORD_WIDTH = 24
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_write_enable,
   input  wire logic        [RES_WIDTH-1:0]   csr_write_data,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_op,
   input  wire logic signed [COORD_WIDTH-1:0] req_pos_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_pos_y,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic             [KIND_WIDTH-1:0]  rsp_kind,
   output logic signed      [COORD_WIDTH-1:0] rsp_out_x,
   output logic signed      [COORD_WIDTH-1:0] rsp_out_y,
   output logic                               rsp_clipped,
   output logic                               rsp_last
);
   localparam int QDW = 2 + 4 * COORD_WIDTH;

   logic [RES_WIDTH-1:0]          resolution_ff;
   logic                          accept, q_full, q_valid, q_pop;
   cmd_type                       front_kind, back_kind;
   logic signed [COORD_WIDTH-1:0] front_ax, front_ay;
   logic [QDW-1:0]                q_head;

   // hold the spacing register
   always_ff @(posedge clock) begin
      if (reset) begin
         resolution_ff <= RES_RESET;
      end else if (csr_write_enable) begin
         resolution_ff <= csr_write_data;
      end
   end

   // take a beat whenever the queue has room
   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   plden_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock(clock), .reset(reset), .accept(accept), .op(req_op),
      .pos_x(req_pos_x), .pos_y(req_pos_y),
      .cmd_kind(front_kind), .anchor_x(front_ax), .anchor_y(front_ay)
   );

   // entry: command, point, anchor before this beat
   plden_queue #(.WIDTH(QDW)) u_queue (
      .clock(clock), .reset(reset),
      .push(accept), .push_data({front_kind, req_pos_x, req_pos_y, front_ax, front_ay}),
      .full(q_full), .pop(q_pop), .not_empty(q_valid), .head(q_head)
   );

   assign back_kind = cmd_type'(q_head[QDW-1 -: 2]);

   plden_back #(.COORD_WIDTH(COORD_WIDTH), .MAX_INSERTS(MAX_INSERTS)) u_back (
      .clock(clock), .reset(reset),
      .cmd_valid(q_valid), .cmd_pop(q_pop), .cmd_kind(back_kind),
      .cmd_x(q_head[4*COORD_WIDTH-1 -: COORD_WIDTH]),
      .cmd_y(q_head[3*COORD_WIDTH-1 -: COORD_WIDTH]),
      .cmd_ax(q_head[2*COORD_WIDTH-1 -: COORD_WIDTH]),
      .cmd_ay(q_head[COORD_WIDTH-1:0]),
      .resolution(resolution_ff),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_kind(rsp_kind),
      .rsp_out_x(rsp_out_x), .rsp_out_y(rsp_out_y),
      .rsp_clipped(rsp_clipped), .rsp_last(rsp_last)
   );
endmodule
`default_nettype wire

// File: sv/plden_queue.sv
`default_nettype none
module plden_queue #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  not_empty,
   output logic      [WIDTH-1:0] head
);
   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       count_ff;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule
`default_nettype wire

// File: sv/plden_front.sv
`default_nettype none
module plden_front
   import plden_pkg::*;
#(
   parameter int COORD_WIDTH = 24
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          accept,
   input  wire logic                          op,
   input  wire logic signed [COORD_WIDTH-1:0] pos_x,
   input  wire logic signed [COORD_WIDTH-1:0] pos_y,
   output cmd_type                            cmd_kind,
   output logic signed      [COORD_WIDTH-1:0] anchor_x,
   output logic signed      [COORD_WIDTH-1:0] anchor_y
);
   logic                          line_start_ff;
   logic signed [COORD_WIDTH-1:0] anchor_x_ff, anchor_y_ff;

   // classify against the state left by the previous beat
   always_comb begin
      if (op == OP_PEN_UP) begin
         cmd_kind = CMD_FLUSH;
      end else if (line_start_ff) begin
         cmd_kind = CMD_START;
      end else begin
         cmd_kind = CMD_SEGMENT;
      end
   end

   assign anchor_x = anchor_x_ff;
   assign anchor_y = anchor_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_start_ff <= 1'b1;
         anchor_x_ff   <= '0;
         anchor_y_ff   <= '0;
      end else if (accept) begin
         if (op == OP_PEN_UP) begin
            line_start_ff <= 1'b1;
         end else begin
            line_start_ff <= 1'b0;
            anchor_x_ff   <= pos_x;
            anchor_y_ff   <= pos_y;
         end
      end
   end
endmodule
`default_nettype wire

// File: sv/plden_div.sv
`default_nettype none
module plden_div #(
   parameter int NUM_WIDTH = 48,
   parameter int DEN_WIDTH = 26
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [NUM_WIDTH-1:0] dividend,
   input  wire logic [DEN_WIDTH-1:0] divisor,
   output logic                      done,
   output logic      [NUM_WIDTH-1:0] quotient,
   output logic      [DEN_WIDTH-1:0] remainder
);
   localparam int ITW = $clog2(NUM_WIDTH + 1);

   logic [NUM_WIDTH-1:0] quo_ff;
   logic [DEN_WIDTH-1:0] rem_ff;
   logic [ITW-1:0]       iter_ff;
   logic                 busy_ff, done_ff;
   logic [DEN_WIDTH:0]   trial;
   logic                 fits;

   // one quotient bit a cycle, restoring
   assign trial = {rem_ff, quo_ff[NUM_WIDTH-1]};
   assign fits  = (trial >= {1'b0, divisor});

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            iter_ff <= ITW'(NUM_WIDTH);
         end else if (busy_ff) begin
            iter_ff <= iter_ff - ITW'(1);
            if (iter_ff == ITW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[NUM_WIDTH-2:0], fits};
         rem_ff <= fits ? DEN_WIDTH'(trial - {1'b0, divisor}) : trial[DEN_WIDTH-1:0];
      end
   end
endmodule
`default_nettype wire

// File: sv/plden_back.sv
`default_nettype none
module plden_back
   import plden_pkg::*;
#(
   parameter int COORD_WIDTH = 24,
   parameter int MAX_INSERTS = 63
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          cmd_valid,
   output logic                               cmd_pop,
   input  cmd_type                            cmd_kind,
   input  wire logic signed [COORD_WIDTH-1:0] cmd_x,
   input  wire logic signed [COORD_WIDTH-1:0] cmd_y,
   input  wire logic signed [COORD_WIDTH-1:0] cmd_ax,
   input  wire logic signed [COORD_WIDTH-1:0] cmd_ay,
   input  wire logic        [RES_WIDTH-1:0]   resolution,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic             [KIND_WIDTH-1:0]  rsp_kind,
   output logic signed      [COORD_WIDTH-1:0] rsp_out_x,
   output logic signed      [COORD_WIDTH-1:0] rsp_out_y,
   output logic                               rsp_clipped,
   output logic                               rsp_last
);
   localparam int CW   = COORD_WIDTH;
   localparam int QW   = CW + 1;
   localparam int SQW  = 2 * CW + 1;
   localparam int CNTW = $clog2(MAX_INSERTS + 2);
   localparam int KW   = RES_WIDTH + CNTW;
   localparam int CMPW = (KW > QW) ? KW : QW;
   localparam int PW   = CW + RES_WIDTH;
   localparam int DVW  = PW + 1;
   localparam int DSW  = QW + 1;
   localparam int ITW  = $clog2(QW + 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_SQUARE, ST_SUM, ST_ROOT, ST_COUNT, ST_MUL, ST_DIV, ST_EMIT, ST_FINAL
   } state_type;

   state_type state_ff;
   cmd_type   kind_ff;

   logic signed [CW-1:0]    x_ff, y_ff, ax_ff, ay_ff;
   logic [CW-1:0]           mag_x_ff, mag_y_ff;
   logic                    neg_x_ff, neg_y_ff;
   logic [2*CW-1:0]         sq_x_ff, sq_y_ff;
   logic [2*QW-1:0]         rad_ff;
   logic [QW:0]             rem_ff;
   logic [QW-1:0]           root_ff;
   logic [ITW-1:0]          iter_ff;
   logic [CNTW-1:0]         k_ff, cnt_ff;
   logic [KW-1:0]           kr_ff;
   logic                    clip_ff;
   logic [PW-1:0]           prod_x_ff, prod_y_ff;
   logic                    div_start_ff;
   logic [CW-1:0]           qacc_x_ff, qacc_y_ff;
   logic [DSW-1:0]          racc_x_ff, racc_y_ff;
   logic                    rsp_valid_ff, rsp_clipped_ff, rsp_last_ff;
   logic [KIND_WIDTH-1:0]   rsp_kind_ff;
   logic signed [CW-1:0]    rsp_x_ff, rsp_y_ff;

   logic [RES_WIDTH-1:0]    res_eff;
   logic signed [CW:0]      dx_c, dy_c, ndx_c, ndy_c;
   logic [QW+2:0]           rem_t, trial_t;
   logic                    root_fit;
   logic                    inside_c;
   logic [CNTW-1:0]         cnt_nx;
   logic                    clip_nx;
   logic                    div_done_x, div_done_y;
   logic [DVW-1:0]          quo_x, quo_y;
   logic [DSW-1:0]          rs_x, rs_y;
   logic [DSW:0]            rsum_x, rsum_y, dden;
   logic                    wrap_x, wrap_y;
   logic [CW-1:0]           qnx_x, qnx_y;
   logic signed [CW:0]      off_x, off_y, sum_x, sum_y;
   logic                    out_free;
   logic                    emit_now;

   assign res_eff  = (resolution == '0) ? RES_WIDTH'(1) : resolution;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign emit_now = out_free && ((state_ff == ST_EMIT) || (state_ff == ST_FINAL));
   assign cmd_pop  = (state_ff == ST_IDLE) && cmd_valid;

   // segment vector
   assign dx_c  = {cmd_x[CW-1], cmd_x} - {cmd_ax[CW-1], cmd_ax};
   assign dy_c  = {cmd_y[CW-1], cmd_y} - {cmd_ay[CW-1], cmd_ay};
   assign ndx_c = -dx_c;
   assign ndy_c = -dy_c;

   // one root digit a cycle
   assign rem_t    = {rem_ff, rad_ff[2*QW-1 -: 2]};
   assign trial_t  = (QW + 3)'({root_ff, 2'b01});
   assign root_fit = (rem_t >= trial_t);

   // k*res < sqrt(s2) exactly: below the floor root, or equal with a remainder
   assign inside_c = (CMPW'(kr_ff) < CMPW'(root_ff))
                  || ((CMPW'(kr_ff) == CMPW'(root_ff)) && (rem_ff != '0));
   assign cnt_nx   = (inside_c && (k_ff <= CNTW'(MAX_INSERTS))) ? k_ff : cnt_ff;
   assign clip_nx  = clip_ff || (inside_c && (k_ff == CNTW'(MAX_INSERTS + 1)));

   plden_div #(.NUM_WIDTH(DVW), .DEN_WIDTH(DSW)) u_div_x (
      .clock(clock), .reset(reset), .start(div_start_ff),
      .dividend({prod_x_ff, 1'b0}), .divisor({root_ff, 1'b0}),
      .done(div_done_x), .quotient(quo_x), .remainder(rs_x)
   );

   plden_div #(.NUM_WIDTH(DVW), .DEN_WIDTH(DSW)) u_div_y (
      .clock(clock), .reset(reset), .start(div_start_ff),
      .dividend({prod_y_ff, 1'b0}), .divisor({root_ff, 1'b0}),
      .done(div_done_y), .quotient(quo_y), .remainder(rs_y)
   );

   // step the rounded offsets by one spacing: add, then at most one wrap
   assign dden   = {1'b0, root_ff, 1'b0};
   assign rsum_x = {1'b0, racc_x_ff} + {1'b0, rs_x};
   assign rsum_y = {1'b0, racc_y_ff} + {1'b0, rs_y};
   assign wrap_x = (rsum_x >= dden);
   assign wrap_y = (rsum_y >= dden);
   assign qnx_x  = qacc_x_ff + quo_x[CW-1:0] + CW'(wrap_x);
   assign qnx_y  = qacc_y_ff + quo_y[CW-1:0] + CW'(wrap_y);
   assign off_x  = neg_x_ff ? -$signed({1'b0, qnx_x}) : $signed({1'b0, qnx_x});
   assign off_y  = neg_y_ff ? -$signed({1'b0, qnx_y}) : $signed({1'b0, qnx_y});
   assign sum_x  = {ax_ff[CW-1], ax_ff} + off_x;
   assign sum_y  = {ay_ff[CW-1], ay_ff} + off_y;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_kind    = rsp_kind_ff;
   assign rsp_out_x   = rsp_x_ff;
   assign rsp_out_y   = rsp_y_ff;
   assign rsp_clipped = rsp_clipped_ff;
   assign rsp_last    = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         div_start_ff <= 1'b0;
      end else begin
         div_start_ff <= (state_ff == ST_MUL);
         if (rsp_valid_ff && rsp_ready && !emit_now) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (cmd_valid) begin
                  kind_ff  <= cmd_kind;
                  x_ff     <= cmd_x;
                  y_ff     <= cmd_y;
                  ax_ff    <= cmd_ax;
                  ay_ff    <= cmd_ay;
                  neg_x_ff <= dx_c[CW];
                  neg_y_ff <= dy_c[CW];
                  mag_x_ff <= dx_c[CW] ? ndx_c[CW-1:0] : dx_c[CW-1:0];
                  mag_y_ff <= dy_c[CW] ? ndy_c[CW-1:0] : dy_c[CW-1:0];
                  clip_ff  <= 1'b0;
                  state_ff <= (cmd_kind == CMD_SEGMENT) ? ST_SQUARE : ST_FINAL;
               end
            end
            ST_SQUARE: begin
               sq_x_ff  <= (2 * CW)'(mag_x_ff) * (2 * CW)'(mag_x_ff);
               sq_y_ff  <= (2 * CW)'(mag_y_ff) * (2 * CW)'(mag_y_ff);
               state_ff <= ST_SUM;
            end
            ST_SUM: begin
               rad_ff   <= (2 * QW)'(SQW'(sq_x_ff) + SQW'(sq_y_ff));
               rem_ff   <= '0;
               root_ff  <= '0;
               iter_ff  <= ITW'(QW);
               state_ff <= ST_ROOT;
            end
            ST_ROOT: begin
               rad_ff  <= {rad_ff[2*QW-3:0], 2'b00};
               rem_ff  <= root_fit ? (QW + 1)'(rem_t - trial_t) : rem_t[QW:0];
               root_ff <= {root_ff[QW-2:0], root_fit};
               iter_ff <= iter_ff - ITW'(1);
               if (iter_ff == ITW'(1)) begin
                  k_ff     <= CNTW'(1);
                  kr_ff    <= KW'(res_eff);
                  cnt_ff   <= '0;
                  state_ff <= ST_COUNT;
               end
            end
            ST_COUNT: begin
               cnt_ff  <= cnt_nx;
               clip_ff <= clip_nx;
               k_ff    <= k_ff + CNTW'(1);
               kr_ff   <= kr_ff + KW'(res_eff);
               if (!inside_c || (k_ff == CNTW'(MAX_INSERTS + 1))) begin
                  state_ff <= (cnt_nx == '0) ? ST_FINAL : ST_MUL;
               end
            end
            ST_MUL: begin
               prod_x_ff    <= PW'(mag_x_ff) * PW'(res_eff);
               prod_y_ff    <= PW'(mag_y_ff) * PW'(res_eff);
               state_ff     <= ST_DIV;
            end
            ST_DIV: begin
               if (div_done_x && div_done_y) begin
                  qacc_x_ff <= '0;
                  qacc_y_ff <= '0;
                  racc_x_ff <= {1'b0, root_ff};
                  racc_y_ff <= {1'b0, root_ff};
                  k_ff      <= CNTW'(1);
                  state_ff  <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  qacc_x_ff      <= qnx_x;
                  qacc_y_ff      <= qnx_y;
                  racc_x_ff      <= wrap_x ? DSW'(rsum_x - dden) : rsum_x[DSW-1:0];
                  racc_y_ff      <= wrap_y ? DSW'(rsum_y - dden) : rsum_y[DSW-1:0];
                  rsp_valid_ff   <= 1'b1;
                  rsp_kind_ff    <= KIND_INSERT;
                  rsp_x_ff       <= sum_x[CW-1:0];
                  rsp_y_ff       <= sum_y[CW-1:0];
                  rsp_clipped_ff <= clip_ff;
                  rsp_last_ff    <= 1'b0;
                  k_ff           <= k_ff + CNTW'(1);
                  if (k_ff == cnt_ff) begin
                     state_ff <= ST_FINAL;
                  end
               end
            end
            ST_FINAL: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_last_ff  <= 1'b1;
                  if (kind_ff == CMD_FLUSH) begin
                     rsp_kind_ff    <= KIND_FLUSH;
                     rsp_x_ff       <= '0;
                     rsp_y_ff       <= '0;
                     rsp_clipped_ff <= 1'b0;
                  end else begin
                     rsp_kind_ff    <= KIND_POINT;
                     rsp_x_ff       <= x_ff;
                     rsp_y_ff       <= y_ff;
                     rsp_clipped_ff <= clip_ff;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end
endmodule
`default_nettype wire

// File: sv/plden_checker.sv
`default_nettype none
module plden_checker
   import plden_pkg::*;
#(
   parameter int COORD_WIDTH = 24
) (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic        [KIND_WIDTH-1:0] rsp_kind,
   input wire logic       [COORD_WIDTH-1:0] rsp_out_x,
   input wire logic       [COORD_WIDTH-1:0] rsp_out_y,
   input wire logic                         rsp_clipped,
   input wire logic                         rsp_last
);
   // a stalled result beat holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_out_x) && $stable(rsp_out_y) && $stable(rsp_last))
      else $error("result beat changed while stalled");

   a_flush: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_FLUSH |->
         rsp_out_x == '0 && rsp_out_y == '0 && !rsp_clipped && rsp_last)
      else $error("malformed flush marker");

   a_insert_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_INSERT |-> !rsp_last)
      else $error("inserted point marked last");

   a_original_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_POINT |-> rsp_last)
      else $error("original point not marked last");

   // clipped stays fixed across the beats of one input
   a_clip_steady: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_kind == KIND_INSERT ##1 rsp_valid
         |-> rsp_clipped == $past(rsp_clipped))
      else $error("clipped changed within one input");
endmodule

bind polyline_densifier plden_checker #(.COORD_WIDTH(COORD_WIDTH)) u_plden_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_kind(rsp_kind), .rsp_out_x(rsp_out_x), .rsp_out_y(rsp_out_y),
   .rsp_clipped(rsp_clipped), .rsp_last(rsp_last)
);
`default_nettype wire
